### rtl/core/itm_pkg.sv
// Shared types and constants for the I2C target mailbox register file.
// Depends on nothing; the other files in rtl/core, except itm_ram and itm_checker, refer to it by scoped names.
package itm_pkg;

  localparam int STORE_DEPTH_DEF    = 256;
  localparam int COMMAND_REGION_DEF = 128;

  localparam logic [7:0] CALL_CODE_RST    = 8'd1;
  localparam logic [7:0] LOCK_CODE_RST    = 8'd2;
  localparam logic [7:0] RETURN_CODE_RST  = 8'd3;
  localparam logic [7:0] COMMAND_SLOT_RST = 8'd1;

  typedef enum logic [2:0] {
    MODE_BUS_START = 3'd0,
    MODE_BUS_WRITE = 3'd1,
    MODE_BUS_STOP  = 3'd2,
    MODE_BUS_READ  = 3'd3,
    MODE_FW_READ   = 3'd4,
    MODE_FW_WORD   = 3'd5,
    MODE_FW_WRITE  = 3'd6,
    MODE_FW_RETURN = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    REG_CALL_CODE    = 2'd0,
    REG_LOCK_CODE    = 2'd1,
    REG_RETURN_CODE  = 2'd2,
    REG_COMMAND_SLOT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD1,
    ST_RD2,
    ST_PEND,
    ST_PWAIT
  } state_t;

  // Which index drives the store port this cycle.
  typedef enum logic [1:0] {
    SRC_ITEM = 2'd0,
    SRC_NEXT = 2'd1,
    SRC_SLOT = 2'd2
  } idx_src_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] bus_byte;
    logic [7:0] fw_address;
    logic [7:0] fw_value;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  pending_command;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     exec;
    idx_src_t src;
    logic     cap_lo;
    logic     cap_hi;
    logic     cap_pend;
  } ctrl_cmd_t;

endpackage

### rtl/core/itm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module itm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/itm_ctrl.sv
// Sequencer for the mailbox: steps one item through execute, reads and
// the pending-command lookup. Depends on itm_pkg.
module itm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  itm_pkg::mode_t     mode,
  output logic               busy,
  output logic               out_valid,
  output itm_pkg::ctrl_cmd_t cmd
);

  itm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.src       = itm_pkg::SRC_ITEM;
    case (state_r)
      itm_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = itm_pkg::ST_EXEC;
        end
      end
      itm_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (mode == itm_pkg::MODE_BUS_READ || mode == itm_pkg::MODE_FW_READ ||
            mode == itm_pkg::MODE_FW_WORD) begin
          state_nxt = itm_pkg::ST_RD1;
        end else begin
          state_nxt = itm_pkg::ST_PEND;
        end
      end
      itm_pkg::ST_RD1: begin
        cmd.cap_lo = 1'b1;
        if (mode == itm_pkg::MODE_FW_WORD) begin
          cmd.src   = itm_pkg::SRC_NEXT;
          state_nxt = itm_pkg::ST_RD2;
        end else begin
          state_nxt = itm_pkg::ST_PEND;
        end
      end
      itm_pkg::ST_RD2: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = itm_pkg::ST_PEND;
      end
      itm_pkg::ST_PEND: begin
        cmd.src   = itm_pkg::SRC_SLOT;
        state_nxt = itm_pkg::ST_PWAIT;
      end
      itm_pkg::ST_PWAIT: begin
        cmd.cap_pend  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = itm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = itm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != itm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/core/itm_dpath.sv
// Datapath for the mailbox: byte store, bus pointer, status byte, config
// registers and result registers. Depends on itm_pkg and itm_ram.
module itm_dpath #(
  parameter int STORE_DEPTH    = itm_pkg::STORE_DEPTH_DEF,
  parameter int COMMAND_REGION = itm_pkg::COMMAND_REGION_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  itm_pkg::in_t       in_item,
  input  itm_pkg::ctrl_cmd_t cmd,
  input  logic               cfg_we,
  input  itm_pkg::cfg_reg_t  cfg_index,
  input  logic [7:0]         cfg_wdata,
  output itm_pkg::mode_t     mode,
  output itm_pkg::out_t      out_result
);

  localparam int AW    = $clog2(STORE_DEPTH);
  // ceil(2^18 / depth); exact quotient for any index up to 256
  localparam int RECIP = ((1 << 18) + STORE_DEPTH - 1) / STORE_DEPTH;

  // Reduce a 9-bit index modulo the store depth by reciprocal multiplication.
  function automatic logic [AW-1:0] slot_of(input logic [8:0] idx);
    logic [26:0] prod;
    logic [8:0]  q;
    logic [17:0] qd;
    logic [17:0] v;
    prod = 27'(idx) * 27'(RECIP);
    q    = prod[26:18];
    qd   = 18'(q) * 18'(STORE_DEPTH);
    v    = 18'(idx) - qd;
    return v[AW-1:0];
  endfunction

  itm_pkg::in_t      item_r;
  logic [7:0]        ptr_r, ptr_nxt;
  logic              loaded_r, loaded_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [7:0]        call_r, lock_r, ret_r, slot_r;
  logic [STORE_DEPTH-1:0] valid_r;
  logic              zero_q_r, valid_q_r;
  logic [15:0]       read_data_r;
  logic [7:0]        pending_r;

  logic [8:0]        raw_idx;
  logic [AW-1:0]     idx;
  logic              idx_zero;
  logic              we;
  logic [7:0]        wdata;
  logic [7:0]        ram_q;
  logic [7:0]        rd_byte;

  always_comb begin
    case (cmd.src)
      itm_pkg::SRC_NEXT: raw_idx = {1'b0, item_r.fw_address} + 9'd1;
      itm_pkg::SRC_SLOT: raw_idx = {1'b0, slot_r};
      default: begin
        if (item_r.mode == itm_pkg::MODE_BUS_WRITE || item_r.mode == itm_pkg::MODE_BUS_READ) begin
          raw_idx = {1'b0, ptr_r};
        end else begin
          raw_idx = {1'b0, item_r.fw_address};
        end
      end
    endcase
  end

  assign idx      = slot_of(raw_idx);
  assign idx_zero = (idx == '0);
  assign wdata    = (item_r.mode == itm_pkg::MODE_FW_WRITE) ? item_r.fw_value
                                                            : item_r.bus_byte;

  always_comb begin
    ptr_nxt    = ptr_r;
    loaded_nxt = loaded_r;
    status_nxt = status_r;
    we         = 1'b0;
    if (cmd.exec) begin
      case (item_r.mode)
        itm_pkg::MODE_BUS_START: begin
          ptr_nxt    = 8'd0;
          loaded_nxt = 1'b0;
        end
        itm_pkg::MODE_BUS_WRITE: begin
          if (!loaded_r) begin
            ptr_nxt    = item_r.bus_byte;
            loaded_nxt = 1'b1;
          end else begin
            // lock first, so a byte landing on the status slot wins
            if ({1'b0, ptr_r} < 9'(COMMAND_REGION)) begin
              status_nxt = lock_r;
            end
            if (idx_zero) begin
              status_nxt = item_r.bus_byte;
            end
            we      = 1'b1;
            ptr_nxt = ptr_r + 8'd1;
          end
        end
        itm_pkg::MODE_BUS_STOP: begin
          if (status_r == lock_r) begin
            status_nxt = call_r;
          end
        end
        itm_pkg::MODE_BUS_READ: begin
          ptr_nxt = ptr_r + 8'd1;
        end
        itm_pkg::MODE_FW_WRITE: begin
          we = 1'b1;
          if (idx_zero) begin
            status_nxt = item_r.fw_value;
          end
        end
        itm_pkg::MODE_FW_RETURN: begin
          status_nxt = ret_r;
        end
        default: begin
        end
      endcase
    end
  end

  itm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (idx),
    .rdata (ram_q)
  );

  // Status slot lives in a register; unwritten entries read as zero.
  assign rd_byte = zero_q_r ? status_r : (valid_q_r ? ram_q : 8'h00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= 8'd0;
      loaded_r <= 1'b0;
      status_r <= 8'd0;
      valid_r  <= '0;
      call_r   <= itm_pkg::CALL_CODE_RST;
      lock_r   <= itm_pkg::LOCK_CODE_RST;
      ret_r    <= itm_pkg::RETURN_CODE_RST;
      slot_r   <= itm_pkg::COMMAND_SLOT_RST;
    end else begin
      ptr_r    <= ptr_nxt;
      loaded_r <= loaded_nxt;
      status_r <= status_nxt;
      if (we) begin
        valid_r[idx] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          itm_pkg::REG_CALL_CODE:    call_r <= cfg_wdata;
          itm_pkg::REG_LOCK_CODE:    lock_r <= cfg_wdata;
          itm_pkg::REG_RETURN_CODE:  ret_r  <= cfg_wdata;
          itm_pkg::REG_COMMAND_SLOT: slot_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    zero_q_r  <= idx_zero;
    valid_q_r <= valid_r[idx];
    if (cmd.load) begin
      item_r      <= in_item;
      read_data_r <= 16'd0;
      pending_r   <= 8'd0;
    end
    if (cmd.cap_lo) begin
      read_data_r[7:0] <= rd_byte;
    end
    if (cmd.cap_hi) begin
      read_data_r[15:8] <= rd_byte;
    end
    if (cmd.cap_pend) begin
      pending_r <= (status_r == call_r) ? rd_byte : 8'h00;
    end
  end

  assign mode                       = item_r.mode;
  assign out_result.read_data       = read_data_r;
  assign out_result.pending_command = pending_r;

endmodule

### rtl/core/i2c_target_mailbox_register_file.sv
// Top level of the I2C target mailbox register file: sequencer plus datapath.
// Depends on itm_pkg, itm_ctrl, itm_dpath (and itm_ram below it).
//
//   Port group  Direction  Handshake           Payload
//   in_         in         start & !busy       in_item (itm_pkg::in_t)
//   out_        out        out_valid strobe    out_result (itm_pkg::out_t)
//   cfg_        in         cfg_we              cfg_index, cfg_wdata
//
// One item at a time. Each item passes ST_EXEC, ST_PEND and ST_PWAIT; a byte read
// adds ST_RD1 and a word read ST_RD1 and ST_RD2: each store access goes through
// the single RAM port with its registered read, and every item ends with a read
// of the command slot. The result strobes for one cycle in the cycle busy has
// dropped. Reset is synchronous; the store needs no clearing pass, since per-entry
// valid bits make unwritten entries read as zero. The receiver cannot stall.
module i2c_target_mailbox_register_file #(
  parameter int STORE_DEPTH    = itm_pkg::STORE_DEPTH_DEF,
  parameter int COMMAND_REGION = itm_pkg::COMMAND_REGION_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  itm_pkg::in_t      in_item,
  output logic              out_valid,
  output itm_pkg::out_t     out_result,
  input  logic              cfg_we,
  input  itm_pkg::cfg_reg_t cfg_index,
  input  logic [7:0]        cfg_wdata
);

  itm_pkg::ctrl_cmd_t cmd;
  itm_pkg::mode_t     mode;

  itm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mode      (mode),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  itm_dpath #(
    .STORE_DEPTH    (STORE_DEPTH),
    .COMMAND_REGION (COMMAND_REGION)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mode       (mode),
    .out_result (out_result)
  );

endmodule

### rtl/core/itm_checker.sv
// Port-level checks on the mailbox's start/busy/result sequencing.
// Depends on i2c_target_mailbox_register_file, to which it is bound.
module itm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

endmodule

bind i2c_target_mailbox_register_file itm_checker u_itm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the I2C target mailbox register file: bus and firmware
// events are driven through the start/busy port and the readbacks are checked against an
// in-bench mailbox model. Depends on itm_pkg and the i2c_target_mailbox_register_file RTL.
module tb_top;
  import itm_pkg::*;

  localparam int STORE_DEPTH    = STORE_DEPTH_DEF;
  localparam int COMMAND_REGION = COMMAND_REGION_DEF;
  localparam int STATUS_IDX     = 0;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int PHASE_ITEMS    = 100;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_t      in_item;
  logic     out_valid;
  out_t     out_result;
  logic     cfg_we;
  cfg_reg_t cfg_index;
  logic [7:0] cfg_wdata;

  i2c_target_mailbox_register_file #(
    .STORE_DEPTH   (STORE_DEPTH),
    .COMMAND_REGION(COMMAND_REGION)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mailbox model state and its copy of the code registers
  logic [7:0] mbox_store [STORE_DEPTH];
  logic [7:0] bus_ptr;
  logic       ptr_loaded;
  logic [7:0] call_code, lock_code, return_code, command_slot;

  in_t  event_q [$];
  out_t readback_q [$];
  int   issued_cnt;
  int   taken_cnt;
  int   fail_cnt;
  int   cycle_cnt;
  logic took_item;
  int   burst_left;
  int   gap_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_t mailbox_apply(in_t it);
    out_t r;
    int   lo, hi;
    r  = '0;
    lo = int'(it.fw_address) % STORE_DEPTH;
    hi = (int'(it.fw_address) + 1) % STORE_DEPTH;
    case (it.mode)
      MODE_BUS_START: begin
        bus_ptr    = '0;
        ptr_loaded = 1'b0;
      end
      MODE_BUS_WRITE: begin
        if (!ptr_loaded) begin
          bus_ptr    = it.bus_byte;
          ptr_loaded = 1'b1;
        end else begin
          // lock goes in before the byte, so a write at index 0 overwrites it
          if (int'(bus_ptr) < COMMAND_REGION) mbox_store[STATUS_IDX] = lock_code;
          mbox_store[int'(bus_ptr) % STORE_DEPTH] = it.bus_byte;
          bus_ptr = bus_ptr + 8'd1;
        end
      end
      MODE_BUS_STOP: begin
        if (mbox_store[STATUS_IDX] == lock_code) mbox_store[STATUS_IDX] = call_code;
      end
      MODE_BUS_READ: begin
        r.read_data = {8'd0, mbox_store[int'(bus_ptr) % STORE_DEPTH]};
        bus_ptr     = bus_ptr + 8'd1;
      end
      MODE_FW_READ:  r.read_data = {8'd0, mbox_store[lo]};
      MODE_FW_WORD:  r.read_data = {mbox_store[hi], mbox_store[lo]};
      MODE_FW_WRITE: mbox_store[lo] = it.fw_value;
      default:       mbox_store[STATUS_IDX] = return_code;
    endcase
    if (mbox_store[STATUS_IDX] == call_code)
      r.pending_command = mbox_store[int'(command_slot) % STORE_DEPTH];
    return r;
  endfunction

  // Sample config writes, check readbacks, predict each accepted transfer
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (mbox_store[i]) mbox_store[i] = '0;
      bus_ptr      = '0;
      ptr_loaded   = 1'b0;
      call_code    = CALL_CODE_RST;
      lock_code    = LOCK_CODE_RST;
      return_code  = RETURN_CODE_RST;
      command_slot = COMMAND_SLOT_RST;
      took_item   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CALL_CODE:    call_code    = cfg_wdata;
          REG_LOCK_CODE:    lock_code    = cfg_wdata;
          REG_RETURN_CODE:  return_code  = cfg_wdata;
          REG_COMMAND_SLOT: command_slot = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (readback_q.size() == 0) begin
          $error("unexpected readback: read_data %0h pending_command %0h",
                 out_result.read_data, out_result.pending_command);
          fail_cnt++;
        end else begin
          want = readback_q.pop_front();
          if (out_result.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_result.read_data);
            fail_cnt++;
          end
          if (out_result.pending_command !== want.pending_command) begin
            $error("pending_command: expected %0h, got %0h",
                   want.pending_command, out_result.pending_command);
            fail_cnt++;
          end
        end
      end
      took_item <= start && !busy;
      if (start && !busy) begin
        readback_q.push_back(mailbox_apply(in_item));
        taken_cnt++;
      end
    end
  end

  // Event driver: bursts of back-to-back events separated by random gaps
  always @(negedge clk) begin
    logic drv_start;
    in_t  drv_item;
    drv_start = start;
    drv_item  = in_item;
    if (took_item) drv_start = 1'b0;
    if (rst_n && !drv_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (event_q.size() > 0) begin
        drv_item  = event_q.pop_front();
        drv_start = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end
    end
    // junk on the payload while no transfer is offered
    if (!drv_start) drv_item = in_t'(27'($urandom));
    start   <= drv_start;
    in_item <= drv_item;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] rbyte();
    return 8'($urandom);
  endfunction

  // Lean toward the command region edge, the wrap point, the command slot and the status byte
  function automatic logic [7:0] pick_index();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(COMMAND_REGION - 4, COMMAND_REGION + 3));
      1:       return 8'($urandom_range(250, 255));
      2:       return command_slot + 8'($urandom_range(0, 2));
      3:       return 8'($urandom_range(0, 3));
      default: return rbyte();
    endcase
  endfunction

  task automatic push_event(mode_t m, logic [7:0] b, logic [7:0] a, logic [7:0] v);
    in_t it;
    it.mode       = m;
    it.bus_byte   = b;
    it.fw_address = a;
    it.fw_value   = v;
    event_q.push_back(it);
    issued_cnt++;
  endtask

  // Hold until every queued event is taken and every readback has come back
  task automatic drain();
    @(negedge clk);
    while (taken_cnt != issued_cnt || readback_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_codes(logic [7:0] c, logic [7:0] l, logic [7:0] r, logic [7:0] s);
    drain();
    write_cfg(REG_CALL_CODE, c);
    write_cfg(REG_LOCK_CODE, l);
    write_cfg(REG_RETURN_CODE, r);
    write_cfg(REG_COMMAND_SLOT, s);
  endtask

  task automatic random_traffic(int count);
    int stop_at;
    int len;
    stop_at = issued_cnt + count;
    while (issued_cnt < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // host write: pointer byte, data bytes, usually a stop
          push_event(MODE_BUS_START, rbyte(), rbyte(), rbyte());
          push_event(MODE_BUS_WRITE, pick_index(), rbyte(), rbyte());
          len = $urandom_range(0, 6);
          repeat (len) push_event(MODE_BUS_WRITE, rbyte(), rbyte(), rbyte());
          if ($urandom_range(0, 7) != 0) push_event(MODE_BUS_STOP, rbyte(), rbyte(), rbyte());
        end
        4, 5: begin
          // host read, with or without a pointer byte first
          push_event(MODE_BUS_START, rbyte(), rbyte(), rbyte());
          if ($urandom_range(0, 3) != 0)
            push_event(MODE_BUS_WRITE, pick_index(), rbyte(), rbyte());
          len = $urandom_range(1, 5);
          repeat (len) push_event(MODE_BUS_READ, rbyte(), rbyte(), rbyte());
          push_event(MODE_BUS_STOP, rbyte(), rbyte(), rbyte());
        end
        6, 7: begin
          // firmware polls status and command, may post a code, then may return
          push_event(MODE_FW_READ, rbyte(), 8'(STATUS_IDX), rbyte());
          push_event(MODE_FW_WORD, rbyte(), pick_index(), rbyte());
          if ($urandom_range(0, 2) == 0)
            push_event(MODE_FW_WRITE, rbyte(), pick_index(), rbyte());
          if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
              0:       push_event(MODE_FW_WRITE, rbyte(), 8'(STATUS_IDX), call_code);
              1:       push_event(MODE_FW_WRITE, rbyte(), 8'(STATUS_IDX), lock_code);
              default: push_event(MODE_FW_WRITE, rbyte(), 8'(STATUS_IDX), rbyte());
            endcase
          end
          if ($urandom_range(0, 1) == 0)
            push_event(MODE_FW_RETURN, rbyte(), rbyte(), rbyte());
        end
        default: begin
          len = $urandom_range(1, 3);
          repeat (len) push_event(mode_t'($urandom_range(0, 7)), rbyte(), rbyte(), rbyte());
        end
      endcase
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_CALL_CODE;
    cfg_wdata  = '0;
    issued_cnt = 0;
    taken_cnt  = 0;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    burst_left = 0;
    gap_left   = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset codes
    push_event(MODE_FW_WRITE, 8'h00, 8'hFF, 8'hFF);
    push_event(MODE_FW_WRITE, 8'hFF, 8'h01, 8'h5A);
    push_event(MODE_FW_WORD,  8'h00, 8'hFF, 8'h00);   // word read wraps to index 0
    push_event(MODE_FW_READ,  8'h00, 8'hFF, 8'h00);
    push_event(MODE_BUS_START, 8'h00, 8'h00, 8'h00);
    push_event(MODE_BUS_READ,  8'h00, 8'h00, 8'h00);  // read before any pointer byte
    push_event(MODE_BUS_READ,  8'hFF, 8'hFF, 8'hFF);
    push_event(MODE_BUS_START, 8'h00, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'd126, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'hFF, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'h00, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'h81, 8'h00, 8'h00);  // first byte outside the command region
    push_event(MODE_BUS_STOP,  8'h00, 8'h00, 8'h00);
    push_event(MODE_FW_READ,   8'h00, 8'h00, 8'h00);
    push_event(MODE_FW_RETURN, 8'h00, 8'h00, 8'h00);
    push_event(MODE_BUS_STOP,  8'h00, 8'h00, 8'h00);  // stop with no lock pending
    push_event(MODE_BUS_START, 8'h00, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'd254, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'h11, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'h22, 8'h00, 8'h00);
    push_event(MODE_BUS_WRITE, 8'h01, 8'h00, 8'h00);  // pointer wrapped to the status byte
    push_event(MODE_BUS_STOP,  8'h00, 8'h00, 8'h00);
    push_event(MODE_FW_WRITE,  8'h00, 8'h00, LOCK_CODE_RST);
    push_event(MODE_BUS_STOP,  8'h00, 8'h00, 8'h00);
    push_event(MODE_FW_WORD,   8'h00, 8'h00, 8'h00);
    random_traffic(PHASE_ITEMS);

    set_codes(8'h00, 8'h00, 8'h00, 8'h00);
    random_traffic(PHASE_ITEMS);
    set_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_traffic(PHASE_ITEMS);
    set_codes(rbyte(), rbyte(), rbyte(), 8'($urandom_range(0, 7)));
    random_traffic(PHASE_ITEMS);

    drain();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && readback_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
